>>> rtl/core/itc3_pkg.sv
// package: item types, codes and shared helpers for the three-channel interval timer
`timescale 1ns / 1ps

package itc3_pkg;

  localparam int NUM_CHANNELS = 3;
  // width of the padded out level vector, at least the three result fields
  localparam int LVL_W = (NUM_CHANNELS > 3) ? NUM_CHANNELS : 3;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_GATE  = 2'd3
  } itc3_kind_e;

  // address of the control word register, also the read-back channel code
  localparam logic [1:0] CTRL_ADDR = 2'd3;

  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LOW   = 2'd1,
    ACC_HIGH  = 2'd2,
    ACC_BOTH  = 2'd3
  } itc3_access_e;

  typedef enum logic [2:0] {
    MODE_INT_TC   = 3'd0,
    MODE_ONE_SHOT = 3'd1,
    MODE_RATE     = 3'd2,
    MODE_SQUARE   = 3'd3,
    MODE_SW_STB   = 3'd4,
    MODE_HW_STB   = 3'd5
  } itc3_mode_e;

  localparam logic [15:0] HI_MASK = 16'hFF00;
  localparam logic [15:0] LO_MASK = 16'h00FF;
  localparam logic [7:0]  CTRL_READ_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] reg_address;
    logic [7:0] write_data;
    logic [1:0] gate_channel;
    logic       gate_level;
  } itc3_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_level_0;
    logic       out_level_1;
    logic       out_level_2;
  } itc3_out_t;

  // per-channel command for one processed request
  typedef struct packed {
    logic       tick;
    logic       wr_ctrl;
    logic       wr_count;
    logic       rd;
    logic       gate;
    logic [7:0] data;
    logic       level;
  } itc3_cmd_t;

  // modes 6 and 7 alias to 2 and 3
  function automatic itc3_mode_e map_mode(logic [2:0] raw);
    itc3_mode_e m;
    case (raw)
      3'd6:    m = MODE_RATE;
      3'd7:    m = MODE_SQUARE;
      default: m = itc3_mode_e'(raw);
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/itc3_channel.sv
// one timer channel: its state registers and single-pass next-state logic
`timescale 1ns / 1ps

module itc3_channel
  import itc3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  itc3_cmd_t cmd_i,
  output logic [7:0] rd_byte_o,
  output logic       out_next_o
);

  logic [15:0]  cnt_q, cnt_d;
  logic [15:0]  reload_q, reload_d;
  logic [15:0]  latch_q, latch_d;
  logic         lv_q, lv_d;
  itc3_mode_e   mode_q, mode_d;
  logic         bcd_q, bcd_d;
  itc3_access_e form_q, form_d;
  logic         wln_q, wln_d;
  logic         rln_q, rln_d;
  logic         armed_q, armed_d;
  logic         loaded_q, loaded_d;
  logic         gate_q, gate_d;
  logic         out_q, out_d;

  logic [15:0]  rd_val;
  logic [15:0]  dec_one;
  logic [15:0]  dec_two;
  itc3_mode_e   new_mode;
  logic         rise;

  assign rd_val   = lv_q ? latch_q : cnt_q;
  assign dec_one  = cnt_q - 16'd1;
  assign dec_two  = cnt_q - 16'd2;
  assign new_mode = map_mode(cmd_i.data[3:1]);
  assign rise     = !gate_q && cmd_i.level;

  // byte the channel returns on a read of its count register
  always_comb begin
    case (form_q)
      ACC_LOW:  rd_byte_o = rd_val[7:0];
      ACC_HIGH: rd_byte_o = rd_val[15:8];
      ACC_BOTH: rd_byte_o = rln_q ? rd_val[7:0] : rd_val[15:8];
      default:  rd_byte_o = 8'd0;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    reload_d = reload_q;
    latch_d  = latch_q;
    lv_d     = lv_q;
    mode_d   = mode_q;
    bcd_d    = bcd_q;
    form_d   = form_q;
    wln_d    = wln_q;
    rln_d    = rln_q;
    armed_d  = armed_q;
    loaded_d = loaded_q;
    gate_d   = gate_q;
    out_d    = out_q;

    if (cmd_i.tick) begin
      if (!armed_q) begin
        // end of the terminal strobe
        if (loaded_q && (mode_q == MODE_SW_STB || mode_q == MODE_HW_STB) && !out_q) begin
          out_d = 1'b1;
        end
      end else if (!loaded_q) begin
        // nothing loaded yet
      end else if (!gate_q && mode_q != MODE_ONE_SHOT && mode_q != MODE_HW_STB) begin
        // gated off
      end else if (mode_q == MODE_SQUARE) begin
        cnt_d = dec_two;
        if (dec_two[15:1] == 15'd0) begin
          out_d = !out_q;
          cnt_d = reload_q;
        end
      end else begin
        cnt_d = dec_one;
        case (mode_q)
          MODE_INT_TC: begin
            if (dec_one == 16'd0) out_d = 1'b1;
          end
          MODE_ONE_SHOT: begin
            if (dec_one == 16'd0) begin
              out_d   = 1'b1;
              armed_d = 1'b0;
            end
          end
          MODE_RATE: begin
            if (dec_one == 16'd1) begin
              out_d = 1'b0;
            end else if (dec_one == 16'd0) begin
              out_d = 1'b1;
              cnt_d = reload_q;
            end
          end
          default: begin
            if (dec_one == 16'd0) begin
              out_d   = 1'b0;
              armed_d = 1'b0;
            end else if (!out_q) begin
              out_d = 1'b1;
            end
          end
        endcase
      end
    end

    if (cmd_i.wr_ctrl) begin
      if (itc3_access_e'(cmd_i.data[5:4]) == ACC_LATCH) begin
        latch_d = cnt_q;
        lv_d    = 1'b1;
        rln_d   = 1'b1;
      end else begin
        mode_d   = new_mode;
        bcd_d    = cmd_i.data[0];
        form_d   = itc3_access_e'(cmd_i.data[5:4]);
        wln_d    = itc3_access_e'(cmd_i.data[5:4]) != ACC_HIGH;
        rln_d    = itc3_access_e'(cmd_i.data[5:4]) != ACC_HIGH;
        armed_d  = 1'b0;
        loaded_d = 1'b0;
        out_d    = new_mode != MODE_INT_TC;
      end
    end

    if (cmd_i.wr_count) begin
      case (form_q)
        ACC_LOW: begin
          reload_d = {8'd0, cmd_i.data};
          cnt_d    = {8'd0, cmd_i.data};
          loaded_d = 1'b1;
          armed_d  = 1'b1;
        end
        ACC_HIGH: begin
          reload_d = {cmd_i.data, 8'd0};
          cnt_d    = {cmd_i.data, 8'd0};
          loaded_d = 1'b1;
          armed_d  = 1'b1;
        end
        ACC_BOTH: begin
          if (wln_q) begin
            reload_d = (reload_q & HI_MASK) | {8'd0, cmd_i.data};
            wln_d    = 1'b0;
          end else begin
            reload_d = (reload_q & LO_MASK) | {cmd_i.data, 8'd0};
            cnt_d    = (reload_q & LO_MASK) | {cmd_i.data, 8'd0};
            loaded_d = 1'b1;
            armed_d  = 1'b1;
            wln_d    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.rd) begin
      case (form_q)
        ACC_LOW, ACC_HIGH: lv_d = 1'b0;
        ACC_BOTH: begin
          if (rln_q) begin
            rln_d = 1'b0;
          end else begin
            rln_d = 1'b1;
            lv_d  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.gate) begin
      gate_d = cmd_i.level;
      if (rise) begin
        if (mode_q == MODE_ONE_SHOT || mode_q == MODE_HW_STB) begin
          cnt_d   = reload_q;
          out_d   = 1'b0;
          armed_d = 1'b1;
        end else if (mode_q == MODE_RATE || mode_q == MODE_SQUARE) begin
          cnt_d   = reload_q;
          armed_d = 1'b1;
        end
      end
      if (!cmd_i.level && (mode_q == MODE_RATE || mode_q == MODE_SQUARE)) begin
        out_d = 1'b1;
      end
    end
  end

  assign out_next_o = out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 16'd0;
      reload_q <= 16'd0;
      latch_q  <= 16'd0;
      lv_q     <= 1'b0;
      mode_q   <= MODE_INT_TC;
      bcd_q    <= 1'b0;
      form_q   <= ACC_LATCH;
      wln_q    <= 1'b1;
      rln_q    <= 1'b1;
      armed_q  <= 1'b0;
      loaded_q <= 1'b0;
      gate_q   <= 1'b1;
      out_q    <= 1'b1;
    end else begin
      cnt_q    <= cnt_d;
      reload_q <= reload_d;
      latch_q  <= latch_d;
      lv_q     <= lv_d;
      mode_q   <= mode_d;
      bcd_q    <= bcd_d;
      form_q   <= form_d;
      wln_q    <= wln_d;
      rln_q    <= rln_d;
      armed_q  <= armed_d;
      loaded_q <= loaded_d;
      gate_q   <= gate_d;
      out_q    <= out_d;
    end
  end

endmodule

>>> rtl/core/interval_timer_three_channel.sv
// top level: request register, channel array, result register
`timescale 1ns / 1ps

// three-channel interval timer. each request (tick, register write, register
// read or gate change) is captured in an input register, worked through all
// channels in one combinational pass, and its result (read byte plus the three
// out levels) lands in the result register on the same edge the channel state
// updates. throughput is one request per clock while out_stall_i is low; a
// request moves from the input register to the result register, raising
// out_valid_o, once the result register is free or draining. the result
// register holds while out_stall_i is high and the input register keeps
// taking a request until it too is full, so the input stalls only when both
// stages are waiting.
// reads of the control address return 0xff; all other non-read requests
// return a read byte of zero.
module interval_timer_three_channel
  import itc3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  itc3_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output itc3_out_t out_data_o
);

  // input request register
  logic     in_vld_q;
  itc3_in_t in_req_q;

  // result register
  logic      out_vld_q;
  itc3_out_t out_res_q, out_res_d;

  logic advance;
  logic in_take;

  itc3_cmd_t  cmd  [NUM_CHANNELS];
  logic [7:0] ch_rd[NUM_CHANNELS];
  logic [LVL_W-1:0] ch_lvl;
  logic [7:0] rd_sel;

  // the pass runs when a request waits and the result slot is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_data_i;
    end
  end

  // per-channel decode of the request
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    always_comb begin
      cmd[c].tick     = advance && in_req_q.kind == KIND_TICK;
      cmd[c].wr_ctrl  = advance && in_req_q.kind == KIND_WRITE &&
                        in_req_q.reg_address == CTRL_ADDR &&
                        in_req_q.write_data[7:6] != CTRL_ADDR &&
                        int'(in_req_q.write_data[7:6]) == c;
      cmd[c].wr_count = advance && in_req_q.kind == KIND_WRITE &&
                        in_req_q.reg_address != CTRL_ADDR &&
                        int'(in_req_q.reg_address) == c;
      cmd[c].rd       = advance && in_req_q.kind == KIND_READ &&
                        in_req_q.reg_address != CTRL_ADDR &&
                        int'(in_req_q.reg_address) == c;
      cmd[c].gate     = advance && in_req_q.kind == KIND_GATE &&
                        int'(in_req_q.gate_channel) == c;
      cmd[c].data     = in_req_q.write_data;
      cmd[c].level    = in_req_q.gate_level;
    end

    itc3_channel u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd[c]),
      .rd_byte_o  (ch_rd[c]),
      .out_next_o (ch_lvl[c])
    );
  end

  // result fields for channels that are not built read zero
  for (genvar p = NUM_CHANNELS; p < LVL_W; p++) begin : g_pad
    assign ch_lvl[p] = 1'b0;
  end

  // read byte select
  always_comb begin
    rd_sel = 8'd0;
    if (in_req_q.kind == KIND_READ) begin
      if (in_req_q.reg_address == CTRL_ADDR) begin
        rd_sel = CTRL_READ_BYTE;
      end else begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (int'(in_req_q.reg_address) == i) rd_sel = ch_rd[i];
        end
      end
    end
  end

  always_comb begin
    out_res_d.read_data   = rd_sel;
    out_res_d.out_level_0 = ch_lvl[0];
    out_res_d.out_level_1 = ch_lvl[1];
    out_res_d.out_level_2 = ch_lvl[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_res_q;

  // a stalled input means both stages are full and the result is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // a control address read yields 0xff
  a_ctrl_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_req_q.kind == KIND_READ && in_req_q.reg_address == CTRL_ADDR)
    |=> (out_valid_o && out_data_o.read_data == CTRL_READ_BYTE))
    else $error("control read did not return 0xff");

  // only reads carry a nonzero byte
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_req_q.kind != KIND_READ) |=> (out_data_o.read_data == 8'd0))
    else $error("non-read request returned a nonzero byte");

endmodule
